/* rtl/md5sh_pkg.sv */
// Shared types, constants and lookup functions for the MD5 stream hasher.
package md5sh_pkg;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} words_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam int BLOCK_WORDS = 16;
	localparam int COUNT_W = 61;

	function automatic logic [31:0] chain_init(input logic [1:0] idx);
		logic [31:0] v;
		case (idx)
			2'd0: v = INIT_A;
			2'd1: v = INIT_B;
			2'd2: v = INIT_C;
			default: v = INIT_D;
		endcase
		return v;
	endfunction

	// word of the block used by a given step
	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [3:0] s;
		logic [3:0] g;
		s = step[3:0];
		case (step[5:4])
			2'd0: g = s;
			2'd1: g = (s << 2) + s + 4'd1;
			2'd2: g = (s << 1) + s + 4'd5;
			default: g = (s << 3) - s;
		endcase
		return g;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] step);
		logic [4:0] r;
		case ({step[5:4], step[1:0]})
			4'd0: r = 5'd7;
			4'd1: r = 5'd12;
			4'd2: r = 5'd17;
			4'd3: r = 5'd22;
			4'd4: r = 5'd5;
			4'd5: r = 5'd9;
			4'd6: r = 5'd14;
			4'd7: r = 5'd20;
			4'd8: r = 5'd4;
			4'd9: r = 5'd11;
			4'd10: r = 5'd16;
			4'd11: r = 5'd23;
			4'd12: r = 5'd6;
			4'd13: r = 5'd10;
			4'd14: r = 5'd15;
			default: r = 5'd21;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] step);
		logic [31:0] k;
		case (step)
			6'd0: k = 32'hd76aa478;
			6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;
			6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;
			6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

endpackage

/* rtl/md5sh_round.sv */
// One MD5 compression step: round function, sum, rotate and word shuffle.
module md5sh_round (
	input  md5sh_pkg::words_t cur,
	input  logic [5:0]        step,
	input  logic [31:0]       msg_word,
	output md5sh_pkg::words_t nxt
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] dbl;

	always_comb begin
		case (step[5:4])
			2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
			2'd2: f = cur.b ^ cur.c ^ cur.d;
			default: f = cur.c ^ (cur.b | ~cur.d);
		endcase
	end

	assign sum = cur.a + f + msg_word + md5sh_pkg::round_const(step);
	// rotate left: upper half of the doubled word shifted left
	assign dbl = {sum, sum} << md5sh_pkg::rot_amount(step);

	assign nxt.a = cur.d;
	assign nxt.b = dbl[63:32] + cur.b;
	assign nxt.c = cur.b;
	assign nxt.d = cur.c;

endmodule

/* rtl/md5_stream_hasher_core.sv */
// MD5 stream hasher top level: byte packing, padding sequencer and digest output.
// Input: the byte that fills a block stalls the input through the 64 compression
//   steps and the chaining add; no bytes are taken while a block is compressed.
// End transfer: a pad state, compression of an extra block if the length does not fit,
//   a length state, the final compression, then 4 digest transfers, one per cycle
//   when not stalled. All compression runs on the single shared round unit.
// Reset: asynchronous, active low; chaining words to the initial constants, byte count
//   and all control cleared. The block buffer has no reset and needs no clearing pass.
module md5_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1; // 64 round steps
	localparam logic [2:0] ST_FIN  = 3'd2; // add working words into chain
	localparam logic [2:0] ST_PAD  = 3'd3; // 0x80 marker, clear the rest
	localparam logic [2:0] ST_LEN  = 3'd4; // bit length into last two words
	localparam logic [2:0] ST_OUT  = 3'd5; // stream the four digest words

	logic [2:0]  state_q;
	logic [2:0]  ret_q;      // where to go after the chaining add
	logic        clr_lo_q;   // length block follows an extra block: clear words 0..13
	logic [5:0]  step_q;
	logic [1:0]  emit_q;
	logic [md5sh_pkg::COUNT_W-1:0] cnt_q;

	logic [31:0] chain_q [4];
	logic [31:0] blk_q [md5sh_pkg::BLOCK_WORDS];
	md5sh_pkg::words_t work_q;
	md5sh_pkg::words_t work_nxt;

	logic        dv_q;
	logic [31:0] dword_q;
	logic [1:0]  didx_q;

	logic        take;
	logic        byte_wr;
	logic        blk_full;
	logic        pad_wr;
	logic        len_wr;
	logic        start;
	logic        out_load;
	logic [5:0]  pos;
	logic [3:0]  wsel;
	logic [1:0]  lane;
	logic [31:0] low_mask;
	logic [31:0] pad_word;
	logic [63:0] bit_len;
	logic [31:0] msg_word;

	assign item_stall = (state_q != ST_IDLE);
	assign take       = item_valid && !item_stall;
	assign byte_wr    = take && has_byte;
	assign pos        = cnt_q[5:0];
	assign wsel       = pos[5:2];
	assign lane       = pos[1:0];
	assign blk_full   = byte_wr && (pos == 6'd63);
	assign pad_wr     = (state_q == ST_PAD);
	assign len_wr     = (state_q == ST_LEN);

	// compression starts on a full block, on a pad that leaves no room for
	// the length, and always after the length is written
	assign start = blk_full || (pad_wr && (pos >= md5sh_pkg::LEN_POS)) || len_wr;

	// keep lanes below the marker, marker in its lane, zeros above
	assign low_mask = (32'h1 << {lane, 3'b000}) - 32'h1;
	assign pad_word = (blk_q[wsel] & low_mask)
		| ({24'h0, md5sh_pkg::PAD_BYTE} << {lane, 3'b000});
	assign bit_len  = {cnt_q, 3'b000};

	assign msg_word = blk_q[md5sh_pkg::msg_index(step_q)];

	md5sh_round u_round (
		.cur      (work_q),
		.step     (step_q),
		.msg_word (msg_word),
		.nxt      (work_nxt)
	);

	assign out_load = (state_q == ST_OUT) && (!dv_q || !digest_stall);

	// sequencer, byte count and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			clr_lo_q <= 1'b0;
			step_q   <= 6'd0;
			emit_q   <= 2'd0;
			cnt_q    <= '0;
			for (int k = 0; k < 4; k++) begin
				chain_q[k] <= md5sh_pkg::chain_init(2'(k));
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (has_byte) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (blk_full) begin
							state_q <= ST_COMP;
							ret_q   <= end_of_message ? ST_PAD : ST_IDLE;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_COMP: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					state_q    <= ret_q;
				end
				ST_PAD: begin
					if (pos >= md5sh_pkg::LEN_POS) begin
						state_q  <= ST_COMP;
						ret_q    <= ST_LEN;
						clr_lo_q <= 1'b1;
					end else begin
						state_q  <= ST_LEN;
						clr_lo_q <= 1'b0;
					end
				end
				ST_LEN: begin
					state_q <= ST_COMP;
					ret_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						emit_q <= emit_q + 2'd1;
						if (emit_q == 2'd3) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							for (int k = 0; k < 4; k++) begin
								chain_q[k] <= md5sh_pkg::chain_init(2'(k));
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working words: loaded from the chain at start, then one step a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3]};
		end else if (state_q == ST_COMP) begin
			work_q <= work_nxt;
		end
	end

	// block buffer: byte lanes, padding marker, length words
	always_ff @(posedge clk) begin
		for (int k = 0; k < md5sh_pkg::BLOCK_WORDS; k++) begin
			if (byte_wr && (wsel == 4'(k))) begin
				if (lane == 2'd0) begin
					blk_q[k] <= {24'h0, data_byte};
				end else begin
					blk_q[k][{lane, 3'b000} +: 8] <= data_byte;
				end
			end else if (pad_wr) begin
				if (wsel == 4'(k)) begin
					blk_q[k] <= pad_word;
				end else if (4'(k) > wsel) begin
					blk_q[k] <= 32'h0;
				end
			end else if (len_wr) begin
				if (k == 14) begin
					blk_q[k] <= bit_len[31:0];
				end else if (k == 15) begin
					blk_q[k] <= bit_len[63:32];
				end else if (clr_lo_q) begin
					blk_q[k] <= 32'h0;
				end
			end
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
		end else if (out_load) begin
			dv_q <= 1'b1;
		end else if (!digest_stall) begin
			dv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dword_q <= chain_q[emit_q];
			didx_q  <= emit_q;
		end
	end

	assign digest_valid = dv_q;
	assign digest_word  = dword_q;
	assign word_index   = didx_q;
	assign last_word    = (didx_q == 2'd3);

	// step counter only runs during compression
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != 6'd0) |-> (state_q == ST_COMP))
		else $error("step counter running outside compression");

	// chaining add follows the last round step
	a_fin_after_63: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> ($past(state_q) == ST_COMP && $past(step_q) == 6'd63))
		else $error("chaining add without full compression");

	// after the digest, the hasher is back at its initial state
	a_out_restore: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_OUT && state_q == ST_IDLE)
		|-> (cnt_q == '0 && chain_q[0] == md5sh_pkg::INIT_A
			&& chain_q[3] == md5sh_pkg::INIT_D))
		else $error("state not restored after digest");

	// a digest word is loaded only while the previous one is gone or leaving
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_q && digest_stall) |-> !out_load)
		else $error("digest register overwritten while stalled");

endmodule
